// File: hw/rtl/tfb_pkg.sv
`default_nettype none
package tfb_pkg;

  localparam int CNT_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int NSLOT    = 5;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // slot order on the wire, lowest bit goes first
  localparam int SLOT_SYNC = 0;
  localparam int SLOT_LEN  = 1;
  localparam int SLOT_TYPE = 2;
  localparam int SLOT_DATA = 3;
  localparam int SLOT_END  = 4;

  typedef struct packed {
    logic [NSLOT-1:0]  mask;
    logic [BYTE_W-1:0] sync_b;
    logic [BYTE_W-1:0] len_b;
    logic [BYTE_W-1:0] type_b;
    logic [BYTE_W-1:0] data_b;
    logic [BYTE_W-1:0] end_b;
    logic              rej;
  } tfb_cmd_t;

  // CRC-8 over one byte, MSB first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tfb_fifo.sv
`default_nettype none
module tfb_fifo
  import tfb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tfb_cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output tfb_cmd_t      head_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  tfb_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == (PTR_W+1)'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tfb_front.sv
`default_nettype none
module tfb_front
  import tfb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 60
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] frame_type,
  input  wire logic [BYTE_W-1:0] pay_len,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              has_data,
  input  wire logic [BYTE_W-1:0] sync_byte,
  input  wire logic              q_full,
  output logic                   q_push,
  output tfb_cmd_t               q_data
);

  logic              in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  flen_r, flen_nxt;
  logic [7:0]        crc_r, crc_nxt;

  logic              accept;
  logic [CNT_W-1:0]  flen_in;
  logic [CNT_W-1:0]  seen_inc;
  logic [7:0]        crc_base;
  logic [7:0]        crc_data;
  logic [7:0]        crc_type;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign flen_in  = pay_len[CNT_W-1:0];
  assign crc_type = crc8_byte(8'h00, frame_type);
  // first item with data chains the type and the byte
  assign crc_base = in_frame_r ? crc_r : crc_type;
  assign crc_data = crc8_byte(crc_base, data_byte);
  assign seen_inc = in_frame_r ? seen_r + 1'b1 : CNT_W'(1);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    seen_nxt      = seen_r;
    flen_nxt      = flen_r;
    crc_nxt       = crc_r;
    q_data        = '0;
    q_data.sync_b = sync_byte;
    q_data.len_b  = pay_len + 8'd2;
    q_data.type_b = frame_type;
    q_data.data_b = data_byte;

    if (!in_frame_r) begin
      if (pay_len > BYTE_W'(MAX_PAYLOAD)) begin
        q_data.mask[SLOT_END] = 1'b1;
        q_data.end_b          = '0;
        q_data.rej            = 1'b1;
      end else begin
        q_data.mask[SLOT_SYNC] = 1'b1;
        q_data.mask[SLOT_LEN]  = 1'b1;
        q_data.mask[SLOT_TYPE] = 1'b1;
        if (flen_in == '0) begin
          // empty payload: crc of the type closes the frame at once
          q_data.mask[SLOT_END] = 1'b1;
          q_data.end_b          = crc_type;
        end else if (!has_data) begin
          in_frame_nxt = 1'b1;
          seen_nxt     = '0;
          flen_nxt     = flen_in;
          crc_nxt      = crc_type;
        end else begin
          q_data.mask[SLOT_DATA] = 1'b1;
          if (seen_inc >= flen_in) begin
            q_data.mask[SLOT_END] = 1'b1;
            q_data.end_b          = crc_data;
          end else begin
            in_frame_nxt = 1'b1;
            seen_nxt     = seen_inc;
            flen_nxt     = flen_in;
            crc_nxt      = crc_data;
          end
        end
      end
    end else if (has_data) begin
      q_data.mask[SLOT_DATA] = 1'b1;
      if (seen_inc >= flen_r) begin
        q_data.mask[SLOT_END] = 1'b1;
        q_data.end_b          = crc_data;
        in_frame_nxt          = 1'b0;
        seen_nxt              = '0;
        flen_nxt              = '0;
        crc_nxt               = '0;
      end else begin
        seen_nxt = seen_inc;
        crc_nxt  = crc_data;
      end
    end
  end

  assign q_push = accept && (q_data.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      seen_r     <= '0;
      flen_r     <= '0;
      crc_r      <= '0;
    end else if (accept) begin
      in_frame_r <= in_frame_nxt;
      seen_r     <= seen_nxt;
      flen_r     <= flen_nxt;
      crc_r      <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tfb_back.sv
`default_nettype none
module tfb_back
  import tfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire tfb_cmd_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic             out_end,
  output logic             out_rej
);

  tfb_cmd_t          cur_r, cur_nxt;
  logic [NSLOT-1:0]  pend_r, pend_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              oe_r, oe_nxt;
  logic              orj_r, orj_nxt;

  logic              adv;
  logic [NSLOT-1:0]  sel;
  logic [NSLOT-1:0]  pend_left;

  assign adv = !ov_r || out_ready;
  assign sel = pend_r & (~pend_r + 1'b1);

  always_comb begin
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    oe_nxt    = oe_r;
    orj_nxt   = orj_r;
    pend_left = pend_r;
    cur_nxt   = cur_r;

    if (adv) begin
      ov_nxt = (pend_r != '0);
      if (pend_r != '0) begin
        pend_left = pend_r & ~sel;
        oe_nxt    = sel[SLOT_END];
        orj_nxt   = sel[SLOT_END] && cur_r.rej;
        unique case (1'b1)
          sel[SLOT_SYNC]: ob_nxt = cur_r.sync_b;
          sel[SLOT_LEN]:  ob_nxt = cur_r.len_b;
          sel[SLOT_TYPE]: ob_nxt = cur_r.type_b;
          sel[SLOT_DATA]: ob_nxt = cur_r.data_b;
          default:        ob_nxt = cur_r.end_b;
        endcase
      end
    end

    // next command loads as the last slot of this one goes out
    q_pop    = q_valid && (pend_left == '0);
    pend_nxt = pend_left;
    if (q_pop) begin
      cur_nxt  = q_head;
      pend_nxt = q_head.mask;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_end   = oe_r;
  assign out_rej   = orj_r;

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ob_r  <= ob_nxt;
    oe_r  <= oe_nxt;
    orj_r <= orj_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/telemetry_frame_builder_crc8.sv
// Channel  Dir  Signals                      Contents
// in_      in   tvalid/tready/tdata/tuser    tdata: frame_type, pay_len, data_byte; tuser: has_data
// out_     out  tvalid/tready/tdata/tlast/tuser  tdata: out_byte; tlast: frame_end; tuser: rejected
// cfg_     in   APB psel/penable/pwrite/paddr/pwdata/prdata/pready  reg 0 at 0x0: sync_byte
//
// An input transfer is taken every cycle while the 4-entry command queue has room; the
// output side then sends one byte per cycle while out_tready is high, so sustained rate
// is set by the output port: header 3 bytes + payload + 1 CRC per frame. Front and back
// stall independently; out_tready low fills the queue, and a full queue drops in_tready.
// Synchronous active-low reset; no clearing sweep, ready right after reset.
`default_nettype none
module telemetry_frame_builder_crc8
  import tfb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] frame_type, [15:8] pay_len, [23:16] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] has_data
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  output logic [0:0]       out_tuser,  // [0] rejected
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic REG_SYNC = 1'b0;

  logic [BYTE_W-1:0] sync_r;
  logic              q_full;
  logic              q_push;
  tfb_cmd_t          q_wdata;
  logic              q_pop;
  logic              q_valid;
  tfb_cmd_t          q_head;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SYNC) ? {24'd0, sync_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= 8'd200;
    end else if (cfg_wr && (cfg_paddr[2] == REG_SYNC)) begin
      sync_r <= cfg_pwdata[7:0];
    end
  end

  tfb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .frame_type  (in_tdata[7:0]),
    .pay_len     (in_tdata[15:8]),
    .data_byte   (in_tdata[23:16]),
    .has_data    (in_tuser[0]),
    .sync_byte   (sync_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  tfb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  tfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_end   (out_tlast),
    .out_rej   (out_tuser[0])
  );

endmodule
`default_nettype wire

// File: dv/telemetry_frame_builder_crc8_tb.sv
module telemetry_frame_builder_crc8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_LEN        = 60;
  localparam logic [7:0]  CRC_POLY       = 8'hD5;
  localparam logic [7:0]  SYNC_RESET     = 8'd200;
  localparam logic [2:0]  ADDR_SYNC      = 3'd0;  // register 0
  localparam logic [2:0]  ADDR_SPARE     = 3'd4;  // no register here
  localparam int          IDLE_PCT       = 14;
  localparam int          TOTAL_ITEMS    = 460;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last;
    logic       rej;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] frame_type, [15:8] pay_len, [23:16] data_byte
  logic [0:0]  in_tuser = '0;   // [0] has_data
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;
  logic [0:0]  out_tuser;       // [0] rejected
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // frame builder shadow state
  logic [7:0]  sync_shadow = SYNC_RESET;
  logic        open_frame = 1'b0;
  logic [5:0]  bytes_taken = '0;
  logic [5:0]  want_len = '0;
  logic [7:0]  crc_acc = '0;

  frame_byte_t pending_bytes[$];
  int          fail_count = 0;
  int          counted_items = 0;
  bit          quiet_run = 1'b0;
  int          hold_trigger = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_cycles = 0;

  telemetry_frame_builder_crc8 #(.MAX_PAYLOAD(MAX_LEN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit-serial CRC-8, MSB first
  function automatic logic [7:0] crc8_shift(input logic [7:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last, input logic rej);
    frame_byte_t fb;
    fb.wire_byte = b;
    fb.last      = last;
    fb.rej       = rej;
    pending_bytes.push_back(fb);
  endfunction

  function automatic void predict_frame_bytes(input logic [7:0] ftype, input logic [7:0] plen,
                                              input logic [7:0] dbyte, input logic has);
    logic take_data;
    take_data = 1'b0;
    if (!open_frame) begin
      if (plen > MAX_LEN) begin
        push_byte(8'h00, 1'b1, 1'b1);
      end else begin
        push_byte(sync_shadow, 1'b0, 1'b0);
        push_byte(plen + 8'd2, 1'b0, 1'b0);
        push_byte(ftype, 1'b0, 1'b0);
        crc_acc     = crc8_shift(8'h00, ftype);
        want_len    = plen[5:0];
        bytes_taken = '0;
        if (want_len == 0) begin
          push_byte(crc_acc, 1'b1, 1'b0);
          crc_acc = '0;
        end else begin
          open_frame = 1'b1;
          take_data  = has;
        end
      end
    end else begin
      take_data = has;
    end
    if (take_data) begin
      push_byte(dbyte, 1'b0, 1'b0);
      crc_acc     = crc8_shift(crc_acc, dbyte);
      bytes_taken = bytes_taken + 6'd1;
      if (bytes_taken >= want_len) begin
        push_byte(crc_acc, 1'b1, 1'b0);
        open_frame  = 1'b0;
        bytes_taken = '0;
        want_len    = '0;
        crc_acc     = '0;
      end
    end
  endfunction

  task automatic send_item(input logic [7:0] ftype, input logic [7:0] plen,
                           input logic [7:0] dbyte, input logic has);
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {dbyte, plen, ftype};
    in_tuser  <= has;
    do @(posedge clk); while (!in_tready);
    if (!open_frame || has) begin
      counted_items++;
    end
    predict_frame_bytes(ftype, plen, dbyte, has);
  endtask

  // payload bytes with occasional empty transfers mixed in
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] plen,
                            input logic first_has, input int noise_pct);
    int remaining;
    send_item(ftype, plen, 8'($urandom), first_has);
    remaining = (plen == 0) ? 0 : (first_has ? plen - 1 : plen);
    while (remaining > 0) begin
      if ($urandom_range(99) < noise_pct) begin
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end else begin
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        remaining--;
      end
    end
  endtask

  task automatic send_random_frame();
    logic [7:0] ftype;
    logic [7:0] plen;
    int         roll;
    roll  = $urandom_range(99);
    ftype = 8'($urandom);
    if (roll < 12) begin
      plen = 8'($urandom_range(MAX_LEN + 1, 255));
      send_item(ftype, plen, 8'($urandom), 1'($urandom_range(1)));
    end else begin
      plen = (roll < 17) ? 8'($urandom_range(MAX_LEN - 10, MAX_LEN))
                         : 8'($urandom_range(0, 12));
      send_frame(ftype, plen, $urandom_range(99) < 75, 8);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_SYNC) begin
      sync_shadow = data[7:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apb_check_sync();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_SYNC;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== sync_shadow) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("sync register read: expected %h, got %h", sync_shadow, cfg_prdata[7:0]);
      end
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_frame_shapes();
    send_item(8'h00, 8'd0, 8'h00, 1'b0);     // empty payload, no data
    send_item(8'hFF, 8'd0, 8'hFF, 1'b1);     // empty payload, data ignored
    send_item(8'h5A, 8'd61, 8'hA5, 1'b1);    // just over the limit
    send_item(8'h3C, 8'd63, 8'h11, 1'b1);
    send_item(8'h00, 8'd128, 8'h7E, 1'b1);
    send_item(8'hFF, 8'd255, 8'hFF, 1'b0);
    send_item(8'h01, 8'd1, 8'hFF, 1'b1);     // one-byte payload closes on its first item
    send_item(8'h80, 8'd1, 8'h00, 1'b1);
    send_item(8'h21, 8'd3, 8'hC3, 1'b0);     // header only, payload follows
    send_item(8'h00, 8'h00, 8'h00, 1'b1);
    send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);    // empty transfer inside a frame
    send_item(8'hAA, 8'h55, 8'hFF, 1'b1);
    send_item(8'h55, 8'hAA, 8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_sync_register();
    apb_check_sync();
    apb_write(ADDR_SYNC, 32'h0000_0000);
    apb_check_sync();
    send_item(8'h42, 8'd2, 8'h01, 1'b1);
    send_item(8'h00, 8'd0, 8'h02, 1'b1);
    wait_drained();
    apb_write(ADDR_SYNC, 32'hFFFF_FFFF);
    apb_check_sync();
    send_item(8'h7F, 8'd0, 8'h00, 1'b0);
    wait_drained();
    apb_write(ADDR_SPARE, 32'h0000_0012);
    apb_check_sync();
    send_item(8'h10, 8'd1, 8'h99, 1'b1);
    // frame left open across a register write; the new value shows at the next header
    send_item(8'hE7, 8'd2, 8'h00, 1'b0);
    wait_drained();
    apb_write(ADDR_SYNC, 32'h0000_003B);
    send_item(8'h00, 8'h00, 8'h5C, 1'b1);
    send_item(8'h00, 8'h00, 8'hC5, 1'b1);
    send_item(8'h0F, 8'd0, 8'h00, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int start_count;
    int goal;
    start_count = counted_items;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      apb_write(ADDR_SYNC, $urandom);
      quiet_run = (phase == 2);
      goal = start_count + (TOTAL_ITEMS - 180) * (phase + 1) / 4;
      while (counted_items < goal) begin
        send_random_frame();
      end
    end
    quiet_run = 1'b0;
    wait_drained();
  endtask

  // receiver holds off while a max-length frame keeps coming
  task automatic test_backpressure();
    hold_trigger++;
    send_frame(8'($urandom), 8'(MAX_LEN), 1'b1, 0);
    wait_drained();
    apb_write(ADDR_SYNC, SYNC_RESET);
    send_frame(8'($urandom), 8'(MAX_LEN), 1'b0, 5);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    frame_byte_t got;
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.wire_byte = out_tdata;
      got.last      = out_tlast;
      got.rej       = out_tuser[0];
      if (pending_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected transfer: byte %h last %b rej %b",
                   got.wire_byte, got.last, got.rej);
        end
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected byte %h last %b rej %b, got byte %h last %b rej %b",
                     want.wire_byte, want.last, want.rej, got.wire_byte, got.last, got.rej);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_frame_shapes();
    test_sync_register();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tfb_pkg.sv
hw/rtl/tfb_fifo.sv
hw/rtl/tfb_front.sv
hw/rtl/tfb_back.sv
hw/rtl/telemetry_frame_builder_crc8.sv
dv/telemetry_frame_builder_crc8_tb.sv
